/* sv/sta_pkg.sv */
// Shared constants and codes for the spin temperature accumulator.
`timescale 1ns / 1ps
package sta_pkg;

  // Request codes carried on in_req_type.
  localparam logic [1:0] REQ_ATOM  = 2'd0;
  localparam logic [1:0] REQ_CLOSE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Bin store geometry.
  localparam int MASK_BINS_DEF = 16;
  localparam int BIN_DEPTH_MAX = 16;

  // Reset value of the temperature scale register, Q0.16.
  localparam logic [15:0] TEMP_SCALE_RST = 16'd22010;

  // Datapath widths.
  localparam int SPIN_W  = 16;
  localparam int MOM_W   = 16;
  localparam int FIELD_W = 24;
  localparam int TEMP_W  = 24;
  localparam int TOT_W   = 48;
  localparam int SUM_W   = 64;
  localparam int NUM_W   = 80;

endpackage

/* sv/spin_temperature_accumulator.sv */
// Spin temperature accumulator: per-bin sums in block memory and a shared multiply/divide sequencer.
//
//  channel | direction | handshake          | contents
//  --------+-----------+--------------------+---------------------------------------------
//  in_     | input     | in_valid/in_stall  | request type, bin, spin, moment, two fields
//  out_    | output    | out_valid/out_stall| bin, frame temperature, mean, flags
//  cfg_    | input     | cfg_wr_en          | temperature scale, Q0.16
//
// An atom sample keeps the block busy until its bin entry is written back: a single
// 34 x 34 bit multiplier is shared over three moment products, nine spin-field products and
// three squares before the read-modify-write of the bin entry.
// A frame close runs, per active bin, two scale products, then up to two 24-step restoring
// divisions for temperature and mean, and waits while the output is stalled.
// The last result of a frame is held in the output register while the next item is accepted.
// Reset and a clear request empty all stores at once through per-entry valid bits; no sweep
// is needed. Reset is synchronous and active low.
`timescale 1ns / 1ps
module spin_temperature_accumulator
  import sta_pkg::*;
#(
  parameter int MASK_BINS = MASK_BINS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  input  logic [3:0]          in_mask_id,
  input  logic signed [15:0]  in_spin_x,
  input  logic signed [15:0]  in_spin_y,
  input  logic signed [15:0]  in_spin_z,
  input  logic [15:0]         in_moment,
  input  logic signed [23:0]  in_field_int_x,
  input  logic signed [23:0]  in_field_int_y,
  input  logic signed [23:0]  in_field_int_z,
  input  logic signed [23:0]  in_field_ext_x,
  input  logic signed [23:0]  in_field_ext_y,
  input  logic signed [23:0]  in_field_ext_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_bin_index,
  output logic [23:0]         out_spin_temp,
  output logic [23:0]         out_mean_temp,
  output logic                out_invalid_bin,
  output logic                out_last_bin
);

  // Only the first sixteen bins can ever be addressed by a four-bit mask.
  localparam int ACTIVE_BINS = (MASK_BINS < BIN_DEPTH_MAX) ? MASK_BINS : BIN_DEPTH_MAX;
  localparam int AW          = (ACTIVE_BINS > 1) ? $clog2(ACTIVE_BINS) : 1;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ATOM    = 4'd1;
  localparam logic [3:0] ST_FR_RD   = 4'd2;
  localparam logic [3:0] ST_FR_M0   = 4'd3;
  localparam logic [3:0] ST_FR_M1   = 4'd4;
  localparam logic [3:0] ST_DIV_LD  = 4'd5;
  localparam logic [3:0] ST_DIV_RUN = 4'd6;
  localparam logic [3:0] ST_DIV_END = 4'd7;
  localparam logic [3:0] ST_TOT     = 4'd8;
  localparam logic [3:0] ST_OUT     = 4'd9;

  // Steps of the atom sequence.
  localparam logic [4:0] STEP_MAG = 5'd12;
  localparam logic [4:0] STEP_SQ0 = 5'd13;
  localparam logic [4:0] STEP_SQ2 = 5'd15;
  localparam logic [4:0] STEP_WB  = 5'd16;

  // Control state.
  logic [3:0]             state_r;
  logic [4:0]             step_r;
  logic [AW-1:0]          bin_r;
  logic [ACTIVE_BINS-1:0] seen_r;
  logic [ACTIVE_BINS-1:0] tot_vld_r;
  logic [TEMP_W-1:0]      frame_count_r;
  logic [15:0]            scale_r;
  logic                   div_mean_r;
  logic [4:0]             div_cnt_r;
  logic                   out_valid_r;

  // Memories: frame sums {cross, dot} and temperature totals.
  logic [2*SUM_W-1:0] frame_mem [ACTIVE_BINS];
  logic [TOT_W-1:0]   total_mem [ACTIVE_BINS];
  logic [2*SUM_W-1:0] frame_rd_r;
  logic [TOT_W-1:0]   total_rd_r;

  // Atom datapath.
  logic signed [SPIN_W-1:0] sp_r [3];
  logic [MOM_W-1:0]         mom_r;
  logic signed [24:0]       h_r [3];
  logic signed [32:0]       s_r [3];
  logic signed [59:0]       acc_r;
  logic signed [59:0]       c_r [3];
  logic [31:0]              m_r [3];
  logic [2:0]               msat_r;
  logic [SUM_W-1:0]         cr_r;
  logic signed [53:0]       d_r;

  // Frame datapath.
  logic [NUM_W-1:0]  num_r;
  logic [SUM_W-1:0]  den_r;
  logic [SUM_W-1:0]  rem_r;
  logic [23:0]       numlo_r;
  logic [TEMP_W-1:0] q_r;
  logic [TEMP_W-1:0] t_r;
  logic              inv_r;
  logic [TOT_W-1:0]  tot_new_r;

  logic [3:0]        out_bin_r;
  logic [TEMP_W-1:0] out_temp_r;
  logic [TEMP_W-1:0] out_mean_r;
  logic              out_inv_r;
  logic              out_last_r;

  // Shared multiplier.
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod;

  logic              in_take;
  logic              out_load;
  logic              frame_we;
  logic              total_we;
  logic              cur_seen;
  logic              cur_tvld;
  logic              last_bin;
  logic [SUM_W-1:0]  cross_old;
  logic signed [SUM_W-1:0] dot_old;
  logic [SUM_W:0]    cr_sum;
  logic [SUM_W-1:0]  cross_new;
  logic signed [SUM_W:0] dot_sum;
  logic [SUM_W-1:0]  dot_new;
  logic [SUM_W:0]    sq_sum;
  logic [SUM_W-1:0]  sq_term;
  logic [TOT_W-1:0]  tot_old;
  logic [TOT_W:0]    tot_sum;
  logic [TOT_W-1:0]  tot_sat;
  logic [SUM_W-1:0]  rem_sh;
  logic [59:0]       cabs [3];
  logic [37:0]       mag [3];
  logic signed [59:0] acc_rnd;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign last_bin = (bin_r == AW'(ACTIVE_BINS - 1));
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign frame_we = (state_r == ST_ATOM) && (step_r == STEP_WB);
  assign total_we = out_load;

  // Entries whose valid bit is clear read as zero.
  assign cur_seen  = seen_r[bin_r];
  assign cross_old = cur_seen ? frame_rd_r[2*SUM_W-1:SUM_W] : '0;
  assign dot_old   = cur_seen ? $signed(frame_rd_r[SUM_W-1:0]) : '0;
  assign cur_tvld  = cur_seen && !dot_old[SUM_W-1] && (dot_old != '0);
  assign tot_old   = tot_vld_r[bin_r] ? total_rd_r : '0;

  // Saturating updates of the bin sums.
  assign cr_sum    = {1'b0, cross_old} + {1'b0, cr_r};
  assign cross_new = cr_sum[SUM_W] ? '1 : cr_sum[SUM_W-1:0];
  assign dot_sum   = 65'(dot_old) + 65'(d_r);
  always_comb begin
    if (dot_sum[SUM_W] != dot_sum[SUM_W-1]) begin
      dot_new = dot_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      dot_new = dot_sum[SUM_W-1:0];
    end
  end

  assign sq_term = msat_r[step_r[1:0] - 2'd1] ? '1 : prod[63:0];
  assign sq_sum  = {1'b0, cr_r} + {1'b0, sq_term};

  assign tot_sum = {1'b0, tot_old} + {25'b0, t_r};
  assign tot_sat = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];

  assign rem_sh  = {rem_r[SUM_W-2:0], numlo_r[23]};

  // Magnitude of each cross component in Q.8, with an overflow flag.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cabs[i] = c_r[i][59] ? 60'(-c_r[i]) : 60'(c_r[i]);
      mag[i]  = cabs[i][59:22];
    end
  end
  // Division by 64 truncated toward zero.
  assign acc_rnd = acc_r + (acc_r[59] ? 60'sd63 : 60'sd0);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_ATOM) begin
      unique case (step_r)
        5'd0:    begin mul_a = 34'(sp_r[0]); mul_b = 34'(mom_r); end
        5'd1:    begin mul_a = 34'(sp_r[1]); mul_b = 34'(mom_r); end
        5'd2:    begin mul_a = 34'(sp_r[2]); mul_b = 34'(mom_r); end
        5'd3:    begin mul_a = 34'(s_r[0]);  mul_b = 34'(h_r[1]); end
        5'd4:    begin mul_a = 34'(s_r[1]);  mul_b = 34'(h_r[0]); end
        5'd5:    begin mul_a = 34'(s_r[1]);  mul_b = 34'(h_r[2]); end
        5'd6:    begin mul_a = 34'(s_r[2]);  mul_b = 34'(h_r[1]); end
        5'd7:    begin mul_a = 34'(s_r[2]);  mul_b = 34'(h_r[0]); end
        5'd8:    begin mul_a = 34'(s_r[0]);  mul_b = 34'(h_r[2]); end
        5'd9:    begin mul_a = 34'(s_r[0]);  mul_b = 34'(h_r[0]); end
        5'd10:   begin mul_a = 34'(s_r[1]);  mul_b = 34'(h_r[1]); end
        5'd11:   begin mul_a = 34'(s_r[2]);  mul_b = 34'(h_r[2]); end
        5'd13:   begin mul_a = 34'(m_r[0]);  mul_b = 34'(m_r[0]); end
        5'd14:   begin mul_a = 34'(m_r[1]);  mul_b = 34'(m_r[1]); end
        5'd15:   begin mul_a = 34'(m_r[2]);  mul_b = 34'(m_r[2]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == ST_FR_M0) begin
      mul_a = 34'(cross_old[31:0]);
      mul_b = 34'(scale_r);
    end else if (state_r == ST_FR_M1) begin
      mul_a = 34'(cross_old[63:32]);
      mul_b = 34'(scale_r);
    end
  end
  assign prod = mul_a * mul_b;

  // Memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[bin_r] <= {cross_new, dot_new};
    end
    frame_rd_r <= frame_mem[bin_r];
  end

  always_ff @(posedge clk) begin
    if (total_we) begin
      total_mem[bin_r] <= tot_new_r;
    end
    total_rd_r <= total_mem[bin_r];
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= '0;
      bin_r         <= '0;
      seen_r        <= '0;
      tot_vld_r     <= '0;
      frame_count_r <= '0;
      scale_r       <= TEMP_SCALE_RST;
      div_mean_r    <= 1'b0;
      div_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      // The output register is refilled as it empties, or held while stalled.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            unique case (in_req_type)
              REQ_ATOM: begin
                if ({1'b0, in_mask_id} < 5'(ACTIVE_BINS)) begin
                  bin_r   <= in_mask_id[AW-1:0];
                  step_r  <= '0;
                  state_r <= ST_ATOM;
                end
              end
              REQ_CLOSE: begin
                if (frame_count_r != '1) begin
                  frame_count_r <= frame_count_r + 1'b1;
                end
                bin_r   <= '0;
                state_r <= ST_FR_RD;
              end
              REQ_CLEAR: begin
                seen_r        <= '0;
                tot_vld_r     <= '0;
                frame_count_r <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ATOM: begin
          if (step_r == STEP_WB) begin
            seen_r[bin_r] <= 1'b1;
            state_r       <= ST_IDLE;
          end
          step_r <= step_r + 1'b1;
        end
        ST_FR_RD:  state_r <= ST_FR_M0;
        ST_FR_M0:  state_r <= ST_FR_M1;
        ST_FR_M1: begin
          div_mean_r <= 1'b0;
          state_r    <= cur_tvld ? ST_DIV_LD : ST_TOT;
        end
        ST_DIV_LD: begin
          div_cnt_r <= '0;
          state_r   <= ({8'b0, num_r} >= {den_r, 24'b0}) ? ST_DIV_END : ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == 5'd23) begin
            state_r <= ST_DIV_END;
          end
        end
        ST_DIV_END: state_r <= div_mean_r ? ST_OUT : ST_TOT;
        ST_TOT: begin
          div_mean_r <= 1'b1;
          state_r    <= ST_DIV_LD;
        end
        ST_OUT: begin
          if (out_load) begin
            tot_vld_r[bin_r] <= 1'b1;
            if (last_bin) begin
              seen_r  <= '0;
              state_r <= ST_IDLE;
            end else begin
              bin_r   <= AW'(bin_r + 1'b1);
              state_r <= ST_FR_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      sp_r[0] <= in_spin_x;
      sp_r[1] <= in_spin_y;
      sp_r[2] <= in_spin_z;
      mom_r   <= in_moment;
      h_r[0]  <= 25'(in_field_int_x) + 25'(in_field_ext_x);
      h_r[1]  <= 25'(in_field_int_y) + 25'(in_field_ext_y);
      h_r[2]  <= 25'(in_field_int_z) + 25'(in_field_ext_z);
      cr_r    <= '0;
    end
    if (state_r == ST_ATOM) begin
      unique case (step_r)
        5'd0, 5'd1, 5'd2: s_r[step_r[1:0]] <= prod[32:0];
        5'd3, 5'd5, 5'd7, 5'd9: acc_r <= prod[59:0];
        5'd4:  c_r[0] <= acc_r - prod[59:0];
        5'd6:  c_r[1] <= acc_r - prod[59:0];
        5'd8:  c_r[2] <= acc_r - prod[59:0];
        5'd10, 5'd11: acc_r <= acc_r + prod[59:0];
        STEP_MAG: begin
          for (int i = 0; i < 3; i++) begin
            m_r[i]    <= mag[i][31:0];
            msat_r[i] <= (mag[i][37:32] != '0);
          end
          d_r <= 54'(acc_rnd >>> 6);
        end
        STEP_SQ0, 5'd14, STEP_SQ2: cr_r <= sq_sum[SUM_W] ? '1 : sq_sum[SUM_W-1:0];
        default: begin
        end
      endcase
    end
    if (state_r == ST_FR_M0) begin
      num_r <= NUM_W'(prod[47:0]);
    end
    if (state_r == ST_FR_M1) begin
      num_r <= num_r + {prod[47:0], 32'b0};
      den_r <= dot_old;
      t_r   <= '0;
      inv_r <= !cur_tvld;
    end
    if (state_r == ST_DIV_LD) begin
      q_r     <= '1;
      rem_r   <= SUM_W'(num_r[NUM_W-1:24]);
      numlo_r <= num_r[23:0];
    end
    if (state_r == ST_DIV_RUN) begin
      numlo_r <= {numlo_r[22:0], 1'b0};
      if (rem_sh >= den_r) begin
        rem_r <= rem_sh - den_r;
        q_r   <= {q_r[22:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[22:0], 1'b0};
      end
    end
    if ((state_r == ST_DIV_END) && !div_mean_r) begin
      t_r <= q_r;
    end
    if (state_r == ST_TOT) begin
      tot_new_r <= tot_sat;
      num_r     <= NUM_W'(tot_sat);
      den_r     <= SUM_W'(frame_count_r);
    end
    if (out_load) begin
      out_bin_r  <= 4'(bin_r);
      out_temp_r <= t_r;
      out_mean_r <= q_r;
      out_inv_r  <= inv_r;
      out_last_r <= last_bin;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_index   = out_bin_r;
  assign out_spin_temp   = out_temp_r;
  assign out_mean_temp   = out_mean_r;
  assign out_invalid_bin = out_inv_r;
  assign out_last_bin    = out_last_r;

  // The running remainder always stays below the divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_RUN) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  // A mean is only ever taken over at least one frame.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TOT) |-> (frame_count_r != '0))
    else $error("mean taken with zero frame count");

  // A flagged bin never reports a temperature.
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid_bin) |-> (out_spin_temp == '0))
    else $error("flagged bin carries a temperature");

  // Closing a frame clears every seen bit once the last bin has been sent.
  a_seen_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_bin) |=> (seen_r == '0) && (state_r == ST_IDLE))
    else $error("frame sums not emptied after frame close");

endmodule

/* verif/spin_temperature_accumulator_tb.sv */
// Self-checking testbench for the spin temperature accumulator: directed table, then random traffic.
`timescale 1ns / 1ps
module spin_temperature_accumulator_tb;
  import sta_pkg::*;

  // Request type 3 is not a defined operation; the block must ignore it.
  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam int         BINS        = MASK_BINS_DEF;
  localparam int         MAX_REPORTS = 10;
  localparam int         STALL_LIMIT = 6000;
  localparam int         LONG_HOLD   = 400;
  localparam int         SETTLE      = 80;
  localparam logic [23:0] TEMP_MAX   = 24'hFFFFFF;
  localparam logic [47:0] TOTAL_MAX  = 48'hFFFFFFFFFFFF;

  // Marks a directed row whose results can be read straight off: every bin empty and every
  // running total zero, so each bin reports zero temperature, zero mean and the invalid flag.
  localparam bit ALL_EMPTY = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         bin;
    logic signed [15:0] sx, sy, sz;
    logic [15:0]        mom;
    logic signed [23:0] hix, hiy, hiz, hex, hey, hez;
    bit                 typed;
  } atom_req_t;

  typedef struct packed {
    logic [3:0]  bin;
    logic [23:0] temp;
    logic [23:0] mean;
    logic        inv;
    logic        last;
  } bin_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = REQ_ATOM;
  logic [3:0] in_mask_id = '0;
  logic signed [15:0] in_spin_x = '0, in_spin_y = '0, in_spin_z = '0;
  logic [15:0] in_moment = '0;
  logic signed [23:0] in_field_int_x = '0, in_field_int_y = '0, in_field_int_z = '0;
  logic signed [23:0] in_field_ext_x = '0, in_field_ext_y = '0, in_field_ext_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_bin_index;
  logic [23:0] out_spin_temp, out_mean_temp;
  logic out_invalid_bin, out_last_bin;

  always #5 clk = ~clk;

  spin_temperature_accumulator DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_mask_id(in_mask_id),
    .in_spin_x(in_spin_x), .in_spin_y(in_spin_y), .in_spin_z(in_spin_z),
    .in_moment(in_moment),
    .in_field_int_x(in_field_int_x), .in_field_int_y(in_field_int_y),
    .in_field_int_z(in_field_int_z),
    .in_field_ext_x(in_field_ext_x), .in_field_ext_y(in_field_ext_y),
    .in_field_ext_z(in_field_ext_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bin_index(out_bin_index), .out_spin_temp(out_spin_temp),
    .out_mean_temp(out_mean_temp), .out_invalid_bin(out_invalid_bin),
    .out_last_bin(out_last_bin)
  );

  // Shadow copy of the block's state, kept in step with every accepted transfer.
  logic [15:0] scale_reg;
  logic [63:0] cross_acc [BINS];
  longint      dot_acc [BINS];
  bit          seen [BINS];
  logic [47:0] temp_sum [BINS];
  logic [23:0] frames;

  bin_report_t pending_reports [$];

  int  errors = 0;
  bit  idle_on = 1'b1;
  bit  hold_go = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  function automatic void clear_frame_sums();
    for (int k = 0; k < BINS; k++) begin
      cross_acc[k] = '0;
      dot_acc[k] = 0;
      seen[k] = 1'b0;
    end
  endfunction

  function automatic void clear_statistics();
    clear_frame_sums();
    for (int k = 0; k < BINS; k++) temp_sum[k] = '0;
    frames = '0;
  endfunction

  // Squared magnitude of one cross-product component, brought down from Q.30 to Q.8 first.
  function automatic logic [63:0] cross_square(longint c);
    logic [63:0] m;
    m = (c < 0) ? 64'(-c) : 64'(c);
    m = m >> 22;
    if (m > 64'hFFFFFFFF) return '1;
    return m * m;
  endfunction

  function automatic logic [63:0] add_unsigned_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[64] ? '1 : r[63:0];
  endfunction

  function automatic longint add_signed_sat(longint a, longint b);
    logic signed [64:0] r;
    r = 65'(a) + 65'(b);
    if (r > 65'sh0_7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
    if (r < -65'sh0_8000000000000000) return 64'sh8000000000000000;
    return longint'(r);
  endfunction

  // Updates the shadow state for one accepted transfer and queues the bin reports it causes.
  function automatic void predict_transfer(atom_req_t r);
    longint s0, s1, s2, h0, h1, h2, d;
    logic [63:0] cr;
    logic [127:0] num, quot;
    logic [23:0] t;
    logic [47:0] mean;
    bin_report_t rep;
    case (r.kind)
      REQ_ATOM: begin
        s0 = longint'(r.sx) * longint'({1'b0, r.mom});
        s1 = longint'(r.sy) * longint'({1'b0, r.mom});
        s2 = longint'(r.sz) * longint'({1'b0, r.mom});
        h0 = longint'(r.hix) + longint'(r.hex);
        h1 = longint'(r.hiy) + longint'(r.hey);
        h2 = longint'(r.hiz) + longint'(r.hez);
        cr = cross_square(s0 * h1 - s1 * h0);
        cr = add_unsigned_sat(cr, cross_square(s1 * h2 - s2 * h1));
        cr = add_unsigned_sat(cr, cross_square(s2 * h0 - s0 * h2));
        d = (s0 * h0 + s1 * h1 + s2 * h2) / 64;
        cross_acc[r.bin] = add_unsigned_sat(cross_acc[r.bin], cr);
        dot_acc[r.bin] = add_signed_sat(dot_acc[r.bin], d);
        seen[r.bin] = 1'b1;
      end
      REQ_CLOSE: begin
        if (frames != 24'hFFFFFF) frames = frames + 1'b1;
        for (int k = 0; k < BINS; k++) begin
          t = '0;
          rep.inv = 1'b1;
          if (seen[k] && dot_acc[k] > 0) begin
            num = 128'(cross_acc[k]) * 128'(scale_reg);
            quot = num / 128'(dot_acc[k]);
            t = (quot > 128'(TEMP_MAX)) ? TEMP_MAX : quot[23:0];
            rep.inv = 1'b0;
          end
          temp_sum[k] = (49'(temp_sum[k]) + 49'(t) > 49'(TOTAL_MAX)) ? TOTAL_MAX
                                                                   : temp_sum[k] + 48'(t);
          mean = temp_sum[k] / 48'(frames);
          rep.bin = k[3:0];
          rep.temp = t;
          rep.mean = (mean > 48'(TEMP_MAX)) ? TEMP_MAX : mean[23:0];
          rep.last = (k == BINS - 1);
          if (r.typed) begin
            rep.temp = '0;
            rep.mean = '0;
            rep.inv = 1'b1;
          end
          pending_reports = {pending_reports, rep};
        end
        clear_frame_sums();
      end
      REQ_CLEAR: clear_statistics();
      default: ;
    endcase
  endfunction

  // Offers one request, with random idle cycles first, and waits for its transfer.
  task automatic send_request(atom_req_t r);
    while (idle_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.kind;
    in_mask_id <= r.bin;
    in_spin_x <= r.sx;
    in_spin_y <= r.sy;
    in_spin_z <= r.sz;
    in_moment <= r.mom;
    in_field_int_x <= r.hix;
    in_field_int_y <= r.hiy;
    in_field_int_z <= r.hiz;
    in_field_ext_x <= r.hex;
    in_field_ext_y <= r.hey;
    in_field_ext_z <= r.hez;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_transfer(r);
  endtask

  function automatic logic signed [15:0] random_spin();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic signed [23:0] random_field();
    if ($urandom_range(2) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(8192)) - 4096);
  endfunction

  function automatic atom_req_t random_request();
    atom_req_t r;
    int pick;
    pick = $urandom_range(99);
    r.kind = (pick < 87) ? REQ_ATOM : (pick < 96) ? REQ_CLOSE :
             (pick < 98) ? REQ_CLEAR : REQ_IGNORED;
    r.bin = 4'($urandom);
    r.sx = random_spin();
    r.sy = random_spin();
    r.sz = random_spin();
    r.mom = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
    r.hix = random_field();
    r.hiy = random_field();
    r.hiz = random_field();
    r.hex = random_field();
    r.hey = random_field();
    r.hez = random_field();
    r.typed = PREDICTED;
    return r;
  endfunction

  // Waits until every queued bin report has come back, then lets the block go quiet.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_scale(logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scale_reg = value;
  endtask

  // Directed rows: the extremes of every field, each request type, empty and negative bins,
  // accumulation within one bin, a saturating temperature and frames after a clear.
  atom_req_t directed_rows [] = '{
    '{REQ_CLOSE, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0,
      24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, ALL_EMPTY},
    '{REQ_ATOM, 4'd0, 16'sd16384, 16'sd0, 16'sd0, 16'd256,
      24'sd256, 24'sd256, 24'sd0, 24'sd0, 24'sd0, 24'sd0, PREDICTED},
    '{REQ_ATOM, 4'd1, -16'sd16384, -16'sd16384, 16'sd16384, 16'hFFFF,
      24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, PREDICTED},
    '{REQ_ATOM, 4'd2, 16'sd16384, 16'sd16384, -16'sd16384, 16'hFFFF,
      24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, PREDICTED},
    '{REQ_ATOM, 4'd3, 16'sd0, 16'sd0, 16'sd0, 16'd0,
      24'sd512, 24'sd512, 24'sd512, 24'sd0, 24'sd0, 24'sd0, PREDICTED},
    '{REQ_ATOM, 4'd4, 16'sd16384, 16'sd0, 16'sd0, 16'd256,
      -24'sd2560, 24'sd100, 24'sd0, 24'sd0, 24'sd0, 24'sd0, PREDICTED},
    '{REQ_ATOM, 4'd15, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF,
      24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, PREDICTED},
    '{REQ_IGNORED, 4'd7, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF,
      24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, PREDICTED},
    '{REQ_ATOM, 4'd0, 16'sd8192, 16'sd8192, 16'sd0, 16'd512,
      24'sd1024, 24'sd256, 24'sd768, 24'sd256, 24'sd0, -24'sd256, PREDICTED},
    '{REQ_CLOSE, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0,
      24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, PREDICTED},
    '{REQ_CLEAR, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0,
      24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, PREDICTED},
    '{REQ_CLOSE, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0,
      24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, ALL_EMPTY},
    '{REQ_ATOM, 4'd5, 16'sd11585, 16'sd0, 16'sd11585, 16'd300,
      24'sd2000, 24'sd50, 24'sd1500, 24'sd0, 24'sd100, 24'sd0, PREDICTED},
    '{REQ_CLOSE, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0,
      24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, PREDICTED},
    '{REQ_CLOSE, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0,
      24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, PREDICTED},
    '{REQ_ATOM, 4'd6, 16'sd16384, 16'sd0, 16'sd0, 16'hFFFF,
      24'sd1, 24'sh7FFFFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0, PREDICTED},
    '{REQ_CLOSE, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0,
      24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, PREDICTED},
    '{REQ_CLEAR, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0,
      24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, PREDICTED}
  };

  // Result side: a random stall in about one cycle in five, a quiet stretch while idling is
  // switched off, and one long hold-off so that the block backs up and stalls its input.
  always @(posedge clk) begin
    if (hold_go && !hold_done && hold_left == 0) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 20);
    end
  end

  // Each transfer of a bin report is compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    bin_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected bin report: bin %0d temp %h mean %h inv %b last %b",
                   out_bin_index, out_spin_temp, out_mean_temp, out_invalid_bin, out_last_bin);
      end else begin
        want = pending_reports.pop_front();
        if (want.bin !== out_bin_index || want.temp !== out_spin_temp ||
            want.mean !== out_mean_temp || want.inv !== out_invalid_bin ||
            want.last !== out_last_bin) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"bin report mismatch: expected bin %0d temp %h mean %h inv %b last %b,",
                      " got bin %0d temp %h mean %h inv %b last %b"},
                     want.bin, want.temp, want.mean, want.inv, want.last, out_bin_index,
                     out_spin_temp, out_mean_temp, out_invalid_bin, out_last_bin);
        end
      end
    end
  end

  // Watchdog: any cycle with a transfer on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("** spin_temperature_accumulator: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [15:0] scale_plan [4];
    scale_reg = TEMP_SCALE_RST;
    clear_statistics();
    scale_plan[0] = 16'hFFFF;
    scale_plan[1] = 16'd0;
    scale_plan[2] = 16'($urandom);
    scale_plan[3] = TEMP_SCALE_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed table runs at the reset value of the scale register.
    foreach (directed_rows[i]) send_request(directed_rows[i]);
    drain_and_settle();

    for (int phase = 0; phase < 4; phase++) begin
      write_scale(scale_plan[phase]);
      idle_on = (phase != 3);
      for (int n = 0; n < 86; ) begin
        atom_req_t r;
        r = random_request();
        if (phase == 1 && n == 20) hold_go = 1'b1;
        if (phase == 2 && n == 40) begin
          // The sender pauses here until every outstanding bin report has been transferred.
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_reports.size() != 0) @(posedge clk);
        end
        send_request(r);
        if (r.kind != REQ_IGNORED) n++;
      end
      // Close the phase so that each scale setting is seen in at least one frame.
      send_request('{REQ_CLOSE, 4'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0,
                     24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, PREDICTED});
      drain_and_settle();
    end

    if (errors == 0) begin
      $display("** spin_temperature_accumulator: PASSED **");
    end else begin
      $display("** spin_temperature_accumulator: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/sta_pkg.sv
sv/spin_temperature_accumulator.sv
verif/spin_temperature_accumulator_tb.sv
